// ===== rtl/core/hhf_pkg.sv =====
// ---------------------------------------------------------------------------
// hhf_pkg: shared types and constants for the HCI H4 packet framer
// Status codes, packet rules, configuration register indexes and the
// result record handed from the framing logic to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

package hhf_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 10;
  localparam int FLEN_W = 11;
  localparam int CALC_W = 17;   // widest header length: 5 + 16-bit field

  localparam logic [13:0] ISO_LEN_MASK = 14'h3fff;

  localparam logic [BYTE_W-1:0] RST_COMMAND_CODE = 8'd1;
  localparam logic [BYTE_W-1:0] RST_ACL_CODE     = 8'd2;
  localparam logic [BYTE_W-1:0] RST_SCO_CODE     = 8'd3;
  localparam logic [BYTE_W-1:0] RST_ISO_CODE     = 8'd5;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_SHORT    = 3'd4
  } frame_status_t;

  typedef enum logic [1:0] {
    RULE_NONE      = 2'd0,
    RULE_SHORT_HDR = 2'd1,   // command and SCO: 4 + byte 3
    RULE_ACL       = 2'd2,
    RULE_ISO       = 2'd3
  } kind_rule_t;

  typedef enum logic [1:0] {
    CFG_COMMAND = 2'd0,
    CFG_ACL     = 2'd1,
    CFG_SCO     = 2'd2,
    CFG_ISO     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] acl;
    logic [BYTE_W-1:0] sco;
    logic [BYTE_W-1:0] iso;
  } type_codes_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  position;
    logic [FLEN_W-1:0] length;
    frame_status_t     status;
  } frame_res_t;

  // Priority: command, ACL, SCO, ISO.
  function automatic kind_rule_t kind_rule(input logic [BYTE_W-1:0] kind,
                                           input type_codes_t codes);
    kind_rule_t r;
    if (kind == codes.command) begin
      r = RULE_SHORT_HDR;
    end else if (kind == codes.acl) begin
      r = RULE_ACL;
    end else if (kind == codes.sco) begin
      r = RULE_SHORT_HDR;
    end else if (kind == codes.iso) begin
      r = RULE_ISO;
    end else begin
      r = RULE_NONE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hhf_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// hhf_cfg_regs: packet type code registers
// Four write-only type code registers with their reset codes.
// ---------------------------------------------------------------------------
`default_nettype none

module hhf_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [hhf_pkg::BYTE_W-1:0] cfg_wdata,
  output hhf_pkg::type_codes_t            codes
);
  import hhf_pkg::*;

  type_codes_t codes_r;
  type_codes_t codes_nxt;

  always_comb begin
    codes_nxt = codes_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COMMAND: codes_nxt.command = cfg_wdata;
        CFG_ACL:     codes_nxt.acl     = cfg_wdata;
        CFG_SCO:     codes_nxt.sco     = cfg_wdata;
        CFG_ISO:     codes_nxt.iso     = cfg_wdata;
        default:     codes_nxt = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= '{command: RST_COMMAND_CODE, acl: RST_ACL_CODE,
                   sco: RST_SCO_CODE, iso: RST_ISO_CODE};
    end else begin
      codes_r <= codes_nxt;
    end
  end

  assign codes = codes_r;

endmodule

`default_nettype wire

// ===== rtl/core/hhf_frame_logic.sv =====
// ---------------------------------------------------------------------------
// hhf_frame_logic: one-byte framing step
// Decode the packet rule, pick up the length field, check size limits and
// produce the result record plus the next framing state.
// ---------------------------------------------------------------------------
`default_nettype none

module hhf_frame_logic #(
  parameter int MAX_PACKET = 1024,
  parameter int CW         = 11
) (
  input  wire logic                       action,
  input  wire logic [hhf_pkg::BYTE_W-1:0] tx_byte,
  input  wire hhf_pkg::type_codes_t       codes,
  input  wire logic [CW-1:0]              bytes_seen_r,
  input  wire logic [hhf_pkg::BYTE_W-1:0] packet_kind_r,
  input  wire logic [hhf_pkg::BYTE_W-1:0] length_low_r,
  input  wire logic [CW-1:0]              expected_total_r,
  output logic [CW-1:0]                   bytes_seen_nxt,
  output logic [hhf_pkg::BYTE_W-1:0]      packet_kind_nxt,
  output logic [hhf_pkg::BYTE_W-1:0]      length_low_nxt,
  output logic [CW-1:0]                   expected_total_nxt,
  output hhf_pkg::frame_res_t             res
);
  import hhf_pkg::*;

  logic [BYTE_W-1:0] kind;
  kind_rule_t        rule;
  logic              at_len_lo;
  logic              at_len_hi;
  logic [15:0]       len_field;
  logic [CALC_W-1:0] total;
  logic [CW-1:0]     seen_inc;
  logic [CALC_W-1:0] len_sel;
  logic [31:0]       pos_ext;
  frame_status_t     status;
  logic              clear;

  assign kind      = (bytes_seen_r == '0) ? tx_byte : packet_kind_r;
  assign rule      = kind_rule(kind, codes);
  assign at_len_lo = (bytes_seen_r == CW'(3));
  assign at_len_hi = (bytes_seen_r == CW'(4));
  assign seen_inc  = bytes_seen_r + CW'(1);
  assign pos_ext   = 32'(bytes_seen_r);

  always_comb begin
    len_field = {tx_byte, length_low_r};
    if (rule == RULE_ISO) begin
      len_field = {2'b00, len_field[13:0] & ISO_LEN_MASK};
    end
    if (at_len_lo && rule == RULE_SHORT_HDR) begin
      total = CALC_W'(4) + CALC_W'(tx_byte);
    end else if (at_len_hi && (rule == RULE_ACL || rule == RULE_ISO)) begin
      total = CALC_W'(5) + CALC_W'(len_field);
    end else begin
      total = CALC_W'(expected_total_r);
    end
  end

  always_comb begin
    clear   = 1'b1;
    len_sel = total;
    if (action) begin
      status  = ST_SHORT;
      len_sel = CALC_W'(expected_total_r);
    end else if (rule == RULE_NONE) begin
      status  = ST_UNKNOWN;
      len_sel = '0;
    end else if (total > CALC_W'(MAX_PACKET)) begin
      status  = ST_TOO_LONG;
      len_sel = '0;
    end else if (total != '0 && CALC_W'(seen_inc) == total) begin
      status = ST_DONE;
    end else if (32'(seen_inc) >= MAX_PACKET) begin
      status = ST_TOO_LONG;
    end else begin
      status = ST_BUSY;
      clear  = 1'b0;
    end
  end

  always_comb begin
    if (clear) begin
      bytes_seen_nxt     = '0;
      packet_kind_nxt    = '0;
      length_low_nxt     = '0;
      expected_total_nxt = '0;
    end else begin
      bytes_seen_nxt     = seen_inc;
      packet_kind_nxt    = kind;
      length_low_nxt     = at_len_lo ? tx_byte : length_low_r;
      expected_total_nxt = total[CW-1:0];
    end
  end

  assign res.out_byte = action ? '0 : tx_byte;
  assign res.position = pos_ext[POS_W-1:0];
  assign res.length   = len_sel[FLEN_W-1:0];
  assign res.status   = status;

endmodule

`default_nettype wire

// ===== rtl/core/hci_h4_packet_framer.sv =====
// ---------------------------------------------------------------------------
// hci_h4_packet_framer: HCI H4 transmit stream packet framer
// Finds packet boundaries in an outgoing H4 byte stream and tags each byte.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transaction per stream byte, with
//   in_action low; a transaction with in_action high marks end of data.
//   Result channel (out_valid/out_ready): exactly one transaction per input
//   transaction, in order: the byte, its offset in the packet, the packet
//   length once the header is known, and a status (in progress, complete,
//   unknown type, too long, ended short).
//   Configuration port: cfg_we writes cfg_wdata into the type code register
//   selected by cfg_index (command, ACL, SCO, ISO). Write only while idle.
// Timing:
//   A transaction accepted on the input channel passes through the input
//   register, then the framing step into the result register, where out_valid
//   rises and the result can be taken. Throughput is one transaction per cycle
//   while out_ready stays high; the framing state update closes in that single
//   step, so consecutive bytes need no gap.
// Reset (rst_n low, synchronous): drop any transaction in flight, restore
//   the default type codes and wait for a type byte.
// Stall: when out_ready is low the result holds, the input register holds
//   one more byte, and in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module hci_h4_packet_framer #(
  parameter int MAX_PACKET = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic [hhf_pkg::BYTE_W-1:0] in_tx_byte,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hhf_pkg::BYTE_W-1:0]      out_byte,
  output logic [hhf_pkg::POS_W-1:0]       out_byte_position,
  output logic [hhf_pkg::FLEN_W-1:0]      out_frame_length,
  output logic [2:0]                      out_frame_status,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [hhf_pkg::BYTE_W-1:0] cfg_wdata
);
  import hhf_pkg::*;

  // Counter width: must hold MAX_PACKET itself.
  localparam int CW = $clog2(MAX_PACKET + 1);

  type_codes_t codes;

  // Input register
  logic              s1_valid_r;
  logic              s1_action_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Framing state
  logic [CW-1:0]     bytes_seen_r;
  logic [BYTE_W-1:0] packet_kind_r;
  logic [BYTE_W-1:0] length_low_r;
  logic [CW-1:0]     expected_total_r;
  logic [CW-1:0]     bytes_seen_nxt;
  logic [BYTE_W-1:0] packet_kind_nxt;
  logic [BYTE_W-1:0] length_low_nxt;
  logic [CW-1:0]     expected_total_nxt;

  // Result register
  logic              out_valid_r;
  frame_res_t        res_r;
  frame_res_t        res_nxt;

  logic advance;   // result register can take a new result
  logic step;      // input register moves into the result register

  assign advance  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  hhf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .codes     (codes)
  );

  hhf_frame_logic #(
    .MAX_PACKET (MAX_PACKET),
    .CW         (CW)
  ) u_frame (
    .action             (s1_action_r),
    .tx_byte            (s1_byte_r),
    .codes              (codes),
    .bytes_seen_r       (bytes_seen_r),
    .packet_kind_r      (packet_kind_r),
    .length_low_r       (length_low_r),
    .expected_total_r   (expected_total_r),
    .bytes_seen_nxt     (bytes_seen_nxt),
    .packet_kind_nxt    (packet_kind_nxt),
    .length_low_nxt     (length_low_nxt),
    .expected_total_nxt (expected_total_nxt),
    .res                (res_nxt)
  );

  // Input register: refill whenever the held byte moves on or none is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_tx_byte;
    end
  end

  // Framing state: advance only when a byte is actually processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r     <= '0;
      packet_kind_r    <= '0;
      length_low_r     <= '0;
      expected_total_r <= '0;
    end else if (step) begin
      bytes_seen_r     <= bytes_seen_nxt;
      packet_kind_r    <= packet_kind_nxt;
      length_low_r     <= length_low_nxt;
      expected_total_r <= expected_total_nxt;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = res_r.out_byte;
  assign out_byte_position = res_r.position;
  assign out_frame_length  = res_r.length;
  assign out_frame_status  = res_r.status;

  // Any final status returns the framer to waiting for a type byte.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_nxt.status != ST_BUSY |=> bytes_seen_r == '0 && expected_total_r == '0)
    else $error("framing state not cleared after final status");

  // The offset counter never reaches the packet size limit.
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bytes_seen_r) < MAX_PACKET)
    else $error("bytes_seen exceeds packet limit");

  // A stored packet length never exceeds the limit.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(expected_total_r) <= MAX_PACKET)
    else $error("expected_total exceeds packet limit");

  // An unknown type is always reported without a packet length.
  a_unknown_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == ST_UNKNOWN |-> out_frame_length == '0)
    else $error("unknown type reported with a packet length");

endmodule

`default_nettype wire

// ===== sim/hci_h4_packet_framer_tb.sv =====
// ---------------------------------------------------------------------------
// hci_h4_packet_framer_tb: self-checking testbench for the HCI H4 packet framer
// Streams H4 packets, broken packets, stray bytes and end-of-data marks into
// the framer under random idling on both channels. A behavioral copy of the
// framing rules tags every accepted byte, and each result transaction is
// checked field by field, in order, against those tags.
// ---------------------------------------------------------------------------
module hci_h4_packet_framer_tb;
  import hhf_pkg::*;

  localparam int FRAME_MAX     = 1024;  // framer MAX_PACKET
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STALL_LIMIT   = 3000;  // watchdog: cycles without any transaction
  localparam int RANDOM_ITEMS  = 120;
  localparam int SETTLE_CYCLES = 4;     // framer latency plus margin
  localparam int PRINT_CAP     = 40;

  // DUT ports; every input has a known value from time zero
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic              in_action = 1'b0;
  logic [BYTE_W-1:0] in_tx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_byte_position;
  logic [FLEN_W-1:0] out_frame_length;
  logic [2:0]        out_frame_status;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_index = CFG_COMMAND;
  logic [BYTE_W-1:0] cfg_wdata = '0;

  // Framing state as the testbench sees it
  type_codes_t type_codes = '{command: RST_COMMAND_CODE, acl: RST_ACL_CODE,
                              sco: RST_SCO_CODE, iso: RST_ISO_CODE};
  int                frame_bytes_seen = 0;
  int                frame_total      = 0;
  logic [BYTE_W-1:0] frame_kind       = '0;
  logic [BYTE_W-1:0] frame_len_low    = '0;

  frame_res_t        expected_frames[$];
  logic [BYTE_W-1:0] stream_q[$];

  int   items_sent     = 0;
  int   results_seen   = 0;
  int   mismatch_count = 0;
  int   idle_cycles    = 0;
  int   sink_wait      = 0;
  logic sender_burst   = 1'b0;
  logic rx_burst       = 1'b0;
  logic hold_off_req   = 1'b0;

  hci_h4_packet_framer #(
    .MAX_PACKET(FRAME_MAX)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_tx_byte       (in_tx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_position(out_byte_position),
    .out_frame_length (out_frame_length),
    .out_frame_status (out_frame_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Framing prediction
  // -------------------------------------------------------------------------

  // Resolve a type byte against the current codes; command wins over ACL,
  // ACL over SCO, SCO over ISO when registers share a value.
  function automatic kind_rule_t rule_of(input logic [BYTE_W-1:0] code);
    if (code == type_codes.command) return RULE_SHORT_HDR;
    if (code == type_codes.acl)     return RULE_ACL;
    if (code == type_codes.sco)     return RULE_SHORT_HDR;
    if (code == type_codes.iso)     return RULE_ISO;
    return RULE_NONE;
  endfunction

  function automatic void clear_frame();
    frame_bytes_seen = 0;
    frame_total      = 0;
    frame_kind       = '0;
    frame_len_low    = '0;
  endfunction

  // Tag one accepted transaction and advance the framing state.
  function automatic frame_res_t predict_frame(input logic act,
                                               input logic [BYTE_W-1:0] data);
    frame_res_t tag;
    kind_rule_t rule;
    int         pos;
    int         hdr_len;
    pos          = frame_bytes_seen;
    tag.out_byte = data;
    tag.position = pos[POS_W-1:0];
    tag.length   = '0;
    tag.status   = ST_BUSY;
    // End of data: report what is open, then start over.
    if (act) begin
      tag.out_byte = '0;
      tag.length   = frame_total[FLEN_W-1:0];
      tag.status   = ST_SHORT;
      clear_frame();
      return tag;
    end
    if (pos == 0) frame_kind = data;
    rule = rule_of(frame_kind);
    if (rule == RULE_NONE) begin
      tag.status = ST_UNKNOWN;
      clear_frame();
      return tag;
    end
    // Length bytes: byte 3 alone for command and SCO, bytes 3 and 4 otherwise.
    if (pos == 3) begin
      frame_len_low = data;
      if (rule == RULE_SHORT_HDR) frame_total = 4 + int'(data);
    end else if (pos == 4 && rule != RULE_SHORT_HDR) begin
      hdr_len = int'({data, frame_len_low});
      if (rule == RULE_ISO) hdr_len = int'(hdr_len[13:0] & ISO_LEN_MASK);
      frame_total = 5 + hdr_len;
    end
    frame_bytes_seen = pos + 1;
    if (frame_total > FRAME_MAX) begin
      tag.status = ST_TOO_LONG;
      clear_frame();
      return tag;
    end
    if (frame_total != 0 && frame_bytes_seen == frame_total) begin
      tag.status = ST_DONE;
    end else if (frame_bytes_seen >= FRAME_MAX) begin
      // size guard: cannot trigger under the length rules, kept for safety
      tag.length = frame_total[FLEN_W-1:0];
      tag.status = ST_TOO_LONG;
      clear_frame();
      return tag;
    end
    tag.length = frame_total[FLEN_W-1:0];
    if (tag.status == ST_DONE) clear_frame();
    return tag;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Send one transaction: idle a random number of cycles, raise valid, hold
  // until accepted, then log the expected tag. Valid stays high on return so
  // a back-to-back transaction never lowers and raises it in one step.
  task automatic push_item(input logic act, input logic [BYTE_W-1:0] data);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_tx_byte <= data;
    do @(posedge clk); while (!in_ready);
    expected_frames.push_back(predict_frame(act, data));
    items_sent++;
  endtask

  task automatic flush_stream();
    foreach (stream_q[i]) push_item(1'b0, stream_q[i]);
    stream_q.delete();
  endtask

  // Drop valid and wait until every expected result is back and the
  // pipeline has settled.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_COMMAND: type_codes.command = value;
      CFG_ACL:     type_codes.acl     = value;
      CFG_SCO:     type_codes.sco     = value;
      CFG_ISO:     type_codes.iso     = value;
      default: ;
    endcase
  endtask

  // Reprogram all four type codes; only ever while the framer is idle.
  task automatic set_type_codes(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] acl,
                                input logic [BYTE_W-1:0] sco, input logic [BYTE_W-1:0] iso);
    drain_results();
    cfg_write(CFG_COMMAND, cmd);
    cfg_write(CFG_ACL, acl);
    cfg_write(CFG_SCO, sco);
    cfg_write(CFG_ISO, iso);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_kind();
    case ($urandom_range(0, 3))
      0:       return type_codes.command;
      1:       return type_codes.acl;
      2:       return type_codes.sco;
      default: return type_codes.iso;
    endcase
  endfunction

  // Mostly short packets, some medium, a few long ones; an ACL or ISO header may then be over the limit.
  function automatic logic [15:0] draw_len(input kind_rule_t rule);
    int          pick;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 85)                    len = 16'($urandom_range(0, 24));
    else if (pick < 95)               len = 16'($urandom_range(25, 200));
    else if (rule == RULE_SHORT_HDR)  len = 16'($urandom_range(201, 255));
    else                              len = 16'($urandom_range(FRAME_MAX - 4, 16'hffff));
    // ISO ignores the top two length bits; fill them anyway
    if (rule == RULE_ISO) len[15:14] = 2'($urandom_range(0, 3));
    return len;
  endfunction

  // Append one packet of the given type byte: header with random handle or
  // opcode bytes, the length field, and random payload. A header over the
  // limit gets no payload since the framer drops back to waiting for a type.
  function automatic void queue_packet(input logic [BYTE_W-1:0] kind,
                                       input logic [15:0] len_field);
    kind_rule_t rule;
    int         body;
    rule = rule_of(kind);
    stream_q.push_back(kind);
    if (rule == RULE_NONE) return;
    stream_q.push_back(8'($urandom_range(0, 255)));
    stream_q.push_back(8'($urandom_range(0, 255)));
    stream_q.push_back(len_field[7:0]);
    if (rule == RULE_SHORT_HDR) begin
      body = int'(len_field[7:0]);
    end else begin
      stream_q.push_back(len_field[15:8]);
      body = (rule == RULE_ISO) ? int'(len_field[13:0] & ISO_LEN_MASK) : int'(len_field);
      if (body + 5 > FRAME_MAX) body = 0;
    end
    repeat (body) stream_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void queue_random_packet();
    logic [BYTE_W-1:0] kind;
    kind = pick_kind();
    queue_packet(kind, draw_len(rule_of(kind)));
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random ready idling, long hold-off on request, checking
  // -------------------------------------------------------------------------

  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // hold ready low long enough for the framer to fill and stall its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (sink_wait > 0) begin
        out_ready <= 1'b0;
        sink_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] result %0d: %0s got %0d, expected %0d",
               $realtime, results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    frame_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected transaction, out_byte", int'(out_byte), -1);
      end else begin
        want = expected_frames.pop_front();
        if (out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(out_byte), int'(want.out_byte));
        if (out_byte_position !== want.position)
          report_mismatch("byte_position", int'(out_byte_position), int'(want.position));
        if (out_frame_length !== want.length)
          report_mismatch("frame_length", int'(out_frame_length), int'(want.length));
        if (out_frame_status !== want.status)
          report_mismatch("frame_status", int'(out_frame_status), int'(want.status));
      end
      results_seen++;
      // draw the idle time before the next result is taken
      sink_wait = rx_burst ? 0 : $urandom_range(0, 10);
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Reset type codes: one packet of each kind, byte extremes, an unknown
  // type, end of data with nothing open and inside a header.
  task automatic test_default_types();
    stream_q = '{RST_COMMAND_CODE, 8'h03, 8'h0c, 8'h02, 8'h00, 8'hff};
    flush_stream();
    // empty SCO: completes on the length byte
    stream_q = '{RST_SCO_CODE, 8'h00, 8'hff, 8'h00};
    flush_stream();
    stream_q = '{RST_ACL_CODE, 8'h01, 8'h20, 8'h01, 8'h00, 8'ha5};
    flush_stream();
    // ISO length 0xc000 masks to zero: completes on byte 4
    stream_q = '{RST_ISO_CODE, 8'h02, 8'h00, 8'h00, 8'hc0};
    flush_stream();
    push_item(1'b0, 8'hff);
    push_item(1'b1, 8'hff);
    push_item(1'b0, RST_COMMAND_CODE);
    push_item(1'b0, 8'h00);
    push_item(1'b1, 8'h00);
  endtask

  // Length limits: headers one past the limit and beyond, ISO ones after masking,
  // end of data with the length known, and one packet of full size.
  task automatic test_size_limits();
    stream_q = '{RST_ACL_CODE, 8'h00, 8'h00, 8'hfc, 8'h03};
    flush_stream();
    stream_q = '{RST_ISO_CODE, 8'h00, 8'h00, 8'hff, 8'hff};
    flush_stream();
    stream_q = '{RST_ISO_CODE, 8'h00, 8'h00, 8'hfc, 8'hc3};
    flush_stream();
    stream_q = '{RST_ACL_CODE, 8'h00, 8'h00, 8'h10, 8'h00, 8'haa, 8'hbb};
    flush_stream();
    push_item(1'b1, 8'h5a);
    queue_packet(RST_ACL_CODE, 16'(FRAME_MAX - 5));
    flush_stream();
  endtask

  // Extreme and shared type codes, checking the priority between kinds.
  task automatic test_type_codes();
    set_type_codes(8'h00, 8'hff, 8'h80, 8'h7f);
    queue_packet(8'h00, 16'd0);
    queue_packet(8'hff, 16'd3);
    queue_packet(8'h80, 16'd2);
    queue_packet(8'h7f, 16'h8001);
    queue_packet(RST_COMMAND_CODE, 16'd0);  // old code, now unknown
    flush_stream();
    set_type_codes(8'h42, 8'h42, 8'h42, 8'h42);
    queue_packet(8'h42, 16'd1);
    flush_stream();
    set_type_codes(8'h10, 8'h20, 8'h20, 8'h20);
    queue_packet(8'h20, 16'd2);
    flush_stream();
    set_type_codes(8'h10, 8'h11, 8'h30, 8'h30);
    queue_packet(8'h30, 16'd1);
    flush_stream();
    set_type_codes(RST_COMMAND_CODE, RST_ACL_CODE, RST_SCO_CODE, RST_ISO_CODE);
  endtask

  // Hold the result side off while the sender keeps offering back to back.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    sender_burst = 1'b1;
    repeat (4) queue_random_packet();
    flush_stream();
    sender_burst = 1'b0;
  endtask

  // Pause the sender until everything is back, then resume mid-stream.
  task automatic test_sender_pause();
    repeat (2) queue_random_packet();
    flush_stream();
    drain_results();
    repeat (2) queue_random_packet();
    flush_stream();
  endtask

  // Mostly well-formed packets with random content; the rest is truncated
  // packets, stray bytes and end-of-data marks. Codes change between phases.
  task automatic test_random_stream();
    int                stop_at;
    int                next_cfg;
    int                next_mode;
    int                pick;
    int                cut;
    logic [BYTE_W-1:0] shared;
    stop_at   = items_sent + RANDOM_ITEMS;
    next_cfg  = items_sent + 40;
    next_mode = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        shared = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: set_type_codes(RST_COMMAND_CODE, RST_ACL_CODE, RST_SCO_CODE, RST_ISO_CODE);
          1: set_type_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          2: set_type_codes(8'hff, 8'h00, 8'hfe, 8'h01);
          default: set_type_codes(shared, shared ^ 8'h01, shared ^ 8'h01, shared);
        endcase
        next_cfg = items_sent + 40;
      end
      if (items_sent >= next_mode) begin
        sender_burst = ($urandom_range(0, 3) == 0);
        rx_burst     = ($urandom_range(0, 3) == 0);
        next_mode    = items_sent + 15;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        queue_random_packet();
        flush_stream();
      end else if (pick < 83) begin
        // cut a packet short and close the stream
        queue_random_packet();
        if (stream_q.size() > 1) begin
          cut = $urandom_range(1, stream_q.size() - 1);
          while (stream_q.size() > cut) void'(stream_q.pop_back());
        end
        flush_stream();
        push_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        push_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        push_item(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) push_item(1'b0, 8'($urandom_range(0, 255)));
      end
    end
    sender_burst = 1'b0;
    rx_burst     = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    // hold reset, then release it at a falling edge
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_default_types();
    test_size_limits();
    test_type_codes();
    test_backpressure();
    test_sender_pause();
    test_random_stream();
    // wait out every expected result plus the pipeline latency
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
